[design/sct_pkg.sv]
// ----------------------------------------------------------------------------
// Sine/cosine Taylor pipeline: shared definitions
// Widths, fixed-point constants, the bundles passed between stages and the
// split magnitude multiplier used by the squaring stage and the term units.
// ----------------------------------------------------------------------------
package sct_pkg;

	// Number of series terms summed.
	localparam int TERMS = 10;

	// Port widths and the binary point of the internal Q8.40 format.
	localparam int IW = 32;
	localparam int OW = 32;
	localparam int FRAC = 40;
	localparam int OUT_SHIFT = FRAC - 30;

	// Angle magnitude widened from Q8.24 to Q8.40.
	localparam int RW = IW + FRAC - 24;
	// The largest magnitude, two to the 47, is below 32 times two pi, so five
	// restoring steps leave a remainder below two pi.
	localparam int RED_STEPS = 5;
	localparam logic [RW-1:0] TWO_PI_Q40 = 48'h6487ED5110B;

	// Reduced angle, its square and the term magnitudes.
	localparam int XW = 43;
	localparam int SQW = 46;
	localparam int TW = 47;

	// Split multiplier for term times x squared.
	localparam int SPL = 23;
	localparam int PRW = TW + SQW;
	localparam int P00W = 2 * SPL;
	localparam int P11W = PRW - P00W;
	localparam int MIDW = P11W + 1;

	// Division by a step through a reciprocal, exact for dividends below
	// two to the NW and steps up to two to the HW.
	localparam int NW = 52;
	localparam int HW = 10;
	localparam int MW = NW + HW;
	localparam int DSPL = MW / 2;
	localparam int DPW = NW + MW;
	localparam int DP00W = 2 * DSPL;
	localparam int DP11W = DPW - DP00W;
	localparam int DMIDW = DP00W + 1;

	// Signed sum of the terms.
	localparam int AW = 52;

	// Cycles from the input transfer edge to the result transfer edge.
	localparam int LATENCY = 10 + 4 * (TERMS - 1);

	localparam logic [PRW-1:0] RND_HALF = PRW'(1) << (FRAC - 1);
	localparam logic [TW-1:0] ONE_Q40 = TW'(1) << FRAC;
	localparam logic [AW-1:0] ACC_RND = AW'(1) << (OUT_SHIFT - 1);
	localparam logic [OW-1:0] VAL_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] VAL_MIN = {1'b1, {(OW-1){1'b0}}};

	// Partial products of one split multiplication.
	typedef struct packed {
		logic [P00W-1:0] p00;
		logic [P11W-1:0] p11;
		logic [MIDW-1:0] mid;
	} pp_t;

	// Step constants of one term unit, for sine and for cosine.
	typedef struct packed {
		logic [HW-1:0] half_sin;
		logic [HW-1:0] half_cos;
		logic [MW-1:0] recip_sin;
		logic [MW-1:0] recip_cos;
	} step_t;

	// Item travelling along the term chain. The sum excludes the current term.
	typedef struct packed {
		logic           vld;
		logic           kind;
		logic           neg;
		logic [SQW-1:0] x2;
		logic [TW-1:0]  mag;
		logic [AW-1:0]  sum;
	} term_bus_t;

	// First half of a magnitude product: four partial products, cross terms added.
	function automatic pp_t mag_pp(input logic [TW-1:0] a, input logic [SQW-1:0] b);
		pp_t pp;
		pp.p00 = P00W'(a[SPL-1:0]) * P00W'(b[SPL-1:0]);
		pp.p11 = P11W'(a[TW-1:SPL]) * P11W'(b[SQW-1:SPL]);
		pp.mid = MIDW'(a[TW-1:SPL]) * MIDW'(b[SPL-1:0])
			+ MIDW'(a[SPL-1:0]) * MIDW'(b[SQW-1:SPL]);
		return pp;
	endfunction

	// Second half: the outer products do not overlap, so they concatenate.
	function automatic logic [PRW-1:0] mag_join(input pp_t pp, input logic [PRW-1:0] rnd);
		return {pp.p11, pp.p00} + (PRW'(pp.mid) << SPL) + rnd;
	endfunction

endpackage

[design/sct_term.sv]
// ----------------------------------------------------------------------------
// Sine/cosine Taylor pipeline: term unit
// Four stages: adds the incoming term to the running sum, multiplies it by
// x squared with rounding, and divides by the factorial step of this unit.
// ----------------------------------------------------------------------------
module sct_term (
	input  logic              clk,
	input  logic              arst_n,
	input  sct_pkg::step_t    step,
	input  sct_pkg::term_bus_t src,
	output sct_pkg::term_bus_t dst
);

	localparam int AW = sct_pkg::AW;
	localparam int TW = sct_pkg::TW;
	localparam int SQW = sct_pkg::SQW;
	localparam int NW = sct_pkg::NW;
	localparam int MW = sct_pkg::MW;
	localparam int PRW = sct_pkg::PRW;
	localparam int DSPL = sct_pkg::DSPL;
	localparam int DPW = sct_pkg::DPW;
	localparam int DP00W = sct_pkg::DP00W;
	localparam int DP11W = sct_pkg::DP11W;
	localparam int DMIDW = sct_pkg::DMIDW;
	localparam int FRAC = sct_pkg::FRAC;
	localparam int HW_SEL = sct_pkg::HW;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic              kind_s1, kind_s2, kind_s3, kind_s4;
	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SQW-1:0]    x2_s1, x2_s2, x2_s3, x2_s4;
	logic [AW-1:0]     sum_s1, sum_s2, sum_s3, sum_s4;
	sct_pkg::pp_t      pp_s1;
	logic [NW-1:0]     n_s2;
	logic [DP00W-1:0]  dp00_s3;
	logic [DP11W-1:0]  dp11_s3;
	logic [DMIDW-1:0]  dmid_s3;
	logic [TW-1:0]     mag_s4;

	logic [AW-1:0]     term_val;
	logic [HW_SEL-1:0] half;
	logic [PRW-1:0]    prod;
	logic [MW-1:0]     recip;
	logic [DPW-1:0]    quot;

	// Signed value of the incoming term, for the running sum.
	assign term_val = src.neg ? (~{{(AW-TW){1'b0}}, src.mag} + AW'(1))
		: {{(AW-TW){1'b0}}, src.mag};

	// Rounding of the product and half the step fold into one constant.
	assign half = kind_s1 ? step.half_cos : step.half_sin;
	assign prod = sct_pkg::mag_join(pp_s1, sct_pkg::RND_HALF | (PRW'(half) << FRAC));

	// Reciprocal of the step selected by the function kind.
	assign recip = kind_s2 ? step.recip_cos : step.recip_sin;
	assign quot = {dp11_s3, dp00_s3} + (DPW'(dmid_s3) << DSPL);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= src.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Payload of the four stages.
	always_ff @(posedge clk) begin
		kind_s1 <= src.kind;
		neg_s1  <= src.neg;
		x2_s1   <= src.x2;
		sum_s1  <= src.sum + term_val;
		pp_s1   <= sct_pkg::mag_pp(src.mag, src.x2);

		kind_s2 <= kind_s1;
		neg_s2  <= neg_s1;
		x2_s2   <= x2_s1;
		sum_s2  <= sum_s1;
		n_s2    <= prod[FRAC+NW-1:FRAC];

		kind_s3 <= kind_s2;
		neg_s3  <= neg_s2;
		x2_s3   <= x2_s2;
		sum_s3  <= sum_s2;
		dp00_s3 <= DP00W'(n_s2[DSPL-1:0]) * DP00W'(recip[DSPL-1:0]);
		dp11_s3 <= DP11W'(n_s2[NW-1:DSPL]) * DP11W'(recip[MW-1:DSPL]);
		dmid_s3 <= DMIDW'(n_s2[NW-1:DSPL]) * DMIDW'(recip[DSPL-1:0])
			+ DMIDW'(n_s2[DSPL-1:0]) * DMIDW'(recip[MW-1:DSPL]);

		// The series alternates, so the next term has the opposite sign.
		// Terms stay below 128, so the quotient fits the term width.
		kind_s4 <= kind_s3;
		neg_s4  <= ~neg_s3;
		x2_s4   <= x2_s3;
		sum_s4  <= sum_s3;
		mag_s4  <= quot[MW+TW-1:MW];
	end

	// Outgoing bundle.
	always_comb begin
		dst.vld  = vld_s4;
		dst.kind = kind_s4;
		dst.neg  = neg_s4;
		dst.x2   = x2_s4;
		dst.mag  = mag_s4;
		dst.sum  = sum_s4;
	end

endmodule

[design/sine_cosine_taylor.sv]
// ----------------------------------------------------------------------------
// Sine/cosine by Taylor series
// The result passes the input stage, reduction, squaring, the chain of four-stage
// term units, and the sum and rounding stages before the result strobe.
// Throughput: one item per cycle; busy is never raised.
// Reset clears every valid bit at once; items in flight are dropped.
// ----------------------------------------------------------------------------
module sine_cosine_taylor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic signed [31:0]  angle,
	output logic                done,
	output logic signed [31:0]  value
);

	localparam int TERMS = sct_pkg::TERMS;
	localparam int RED_STEPS = sct_pkg::RED_STEPS;
	localparam int RW = sct_pkg::RW;
	localparam int IW = sct_pkg::IW;
	localparam int OW = sct_pkg::OW;
	localparam int XW = sct_pkg::XW;
	localparam int SQW = sct_pkg::SQW;
	localparam int TW = sct_pkg::TW;
	localparam int AW = sct_pkg::AW;
	localparam int MW = sct_pkg::MW;
	localparam int HW = sct_pkg::HW;
	localparam int PRW = sct_pkg::PRW;
	localparam int FRAC = sct_pkg::FRAC;
	localparam int OUT_SHIFT = sct_pkg::OUT_SHIFT;

	logic              accept;
	logic [IW-1:0]     ang_mag;

	logic              rd_vld_s  [RED_STEPS+1];
	logic              rd_kind_s [RED_STEPS+1];
	logic              rd_neg_s  [RED_STEPS+1];
	logic [RW-1:0]     rd_rem_s  [RED_STEPS+1];

	logic              sq_vld_s1, sq_vld_s2;
	logic              sq_kind_s1, sq_kind_s2;
	logic              sq_neg_s1, sq_neg_s2;
	logic [XW-1:0]     sq_x_s1, sq_x_s2;
	sct_pkg::pp_t      sq_pp_s1;
	logic [SQW-1:0]    sq_x2_s2;
	logic [PRW-1:0]    sq_prod;

	sct_pkg::term_bus_t chain [TERMS];

	logic [AW-1:0]     last_val;
	logic              fin_vld_s1, fin_vld_s2;
	logic [AW-1:0]     fin_acc_s1;
	logic [OW-1:0]     fin_val_s2;
	logic [AW-1:0]     rnd_sum;
	logic [AW-OUT_SHIFT-OW:0] rnd_hi;

	// The receiver cannot stall, so every item moves on each cycle.
	assign busy = 1'b0;
	assign accept = start & ~busy;

	// Magnitude of the angle; the most negative angle maps to two to the 31.
	assign ang_mag = angle[IW-1] ? (~$unsigned(angle) + IW'(1)) : $unsigned(angle);

	// Input stage: sign and magnitude widened to Q8.40.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s[0] <= 1'b0;
		end else begin
			rd_vld_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		rd_kind_s[0] <= kind;
		rd_neg_s[0]  <= angle[IW-1];
		rd_rem_s[0]  <= {ang_mag, {(RW-IW){1'b0}}};
	end

	// Restoring reduction by two pi, one quotient bit per stage.
	for (genvar i = 1; i <= RED_STEPS; i++) begin : g_red
		localparam logic [RW-1:0] DIV = sct_pkg::TWO_PI_Q40 << (RED_STEPS - i);
		logic [RW-1:0] rem_nxt;

		assign rem_nxt = (rd_rem_s[i-1] >= DIV) ? (rd_rem_s[i-1] - DIV) : rd_rem_s[i-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_vld_s[i] <= 1'b0;
			end else begin
				rd_vld_s[i] <= rd_vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rd_kind_s[i] <= rd_kind_s[i-1];
			rd_neg_s[i]  <= rd_neg_s[i-1];
			rd_rem_s[i]  <= rem_nxt;
		end
	end

	// Squaring of the reduced angle over two stages.
	assign sq_prod = sct_pkg::mag_join(sq_pp_s1, sct_pkg::RND_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
		end else begin
			sq_vld_s1 <= rd_vld_s[RED_STEPS];
			sq_vld_s2 <= sq_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_kind_s1 <= rd_kind_s[RED_STEPS];
		sq_neg_s1  <= rd_neg_s[RED_STEPS];
		sq_x_s1    <= rd_rem_s[RED_STEPS][XW-1:0];
		sq_pp_s1   <= sct_pkg::mag_pp({{(TW-XW){1'b0}}, rd_rem_s[RED_STEPS][XW-1:0]},
			{{(SQW-XW){1'b0}}, rd_rem_s[RED_STEPS][XW-1:0]});

		sq_kind_s2 <= sq_kind_s1;
		sq_neg_s2  <= sq_neg_s1;
		sq_x_s2    <= sq_x_s1;
		sq_x2_s2   <= sq_prod[FRAC+SQW-1:FRAC];
	end

	// First term: x for sine, one for cosine; nothing summed yet.
	always_comb begin
		chain[0].vld  = sq_vld_s2;
		chain[0].kind = sq_kind_s2;
		chain[0].neg  = sq_kind_s2 ? 1'b0 : sq_neg_s2;
		chain[0].x2   = sq_x2_s2;
		chain[0].mag  = sq_kind_s2 ? sct_pkg::ONE_Q40 : {{(TW-XW){1'b0}}, sq_x_s2};
		chain[0].sum  = '0;
	end

	// One term unit per further term, each with its own factorial step.
	for (genvar k = 1; k < TERMS; k++) begin : g_term
		localparam int D_SIN = (2 * k) * (2 * k + 1);
		localparam int D_COS = (2 * k - 1) * (2 * k);
		localparam logic [63:0] R_SIN = ((64'd1 << MW) + 64'(D_SIN) - 64'd1) / 64'(D_SIN);
		localparam logic [63:0] R_COS = ((64'd1 << MW) + 64'(D_COS) - 64'd1) / 64'(D_COS);
		localparam logic [31:0] H_SIN = D_SIN / 2;
		localparam logic [31:0] H_COS = D_COS / 2;
		localparam sct_pkg::step_t STEP = '{
			half_sin:  H_SIN[HW-1:0],
			half_cos:  H_COS[HW-1:0],
			recip_sin: R_SIN[MW-1:0],
			recip_cos: R_COS[MW-1:0]
		};

		sct_term u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP),
			.src    (chain[k-1]),
			.dst    (chain[k])
		);
	end

	// Last term joins the sum.
	assign last_val = chain[TERMS-1].neg
		? (~{{(AW-TW){1'b0}}, chain[TERMS-1].mag} + AW'(1))
		: {{(AW-TW){1'b0}}, chain[TERMS-1].mag};

	// Round half up to Q2.30 and saturate.
	assign rnd_sum = fin_acc_s1 + sct_pkg::ACC_RND;
	assign rnd_hi = rnd_sum[AW-1:OUT_SHIFT+OW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s1 <= 1'b0;
			fin_vld_s2 <= 1'b0;
		end else begin
			fin_vld_s1 <= chain[TERMS-1].vld;
			fin_vld_s2 <= fin_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		fin_acc_s1 <= chain[TERMS-1].sum + last_val;
		if ((&rnd_hi) | ~(|rnd_hi)) begin
			fin_val_s2 <= rnd_sum[OUT_SHIFT+OW-1:OUT_SHIFT];
		end else if (rnd_sum[AW-1]) begin
			fin_val_s2 <= sct_pkg::VAL_MIN;
		end else begin
			fin_val_s2 <= sct_pkg::VAL_MAX;
		end
	end

	assign done = fin_vld_s2;
	assign value = $signed(fin_val_s2);

endmodule

[design/sct_checker.sv]
// ----------------------------------------------------------------------------
// Sine/cosine Taylor pipeline: port checker
// Watches the top level's ports: fixed latency in both directions and the
// exact results for a zero angle.
// ----------------------------------------------------------------------------
module sct_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               kind,
	input logic signed [31:0] angle,
	input logic               done,
	input logic signed [31:0] value
);

	localparam int LAT = sct_pkg::LATENCY;

	// Every input transfer produces a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("no result after an input transfer");

	// A result strobe always has an input transfer behind it.
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching input transfer");

	// Cosine of zero is exactly one.
	a_cos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind && angle == 32'sd0 |-> ##LAT value == 32'sh4000_0000)
		else $error("cosine of zero is not one");

	// Sine of zero is exactly zero.
	a_sin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !kind && angle == 32'sd0 |-> ##LAT value == 32'sd0)
		else $error("sine of zero is not zero");

endmodule

bind sine_cosine_taylor sct_checker u_sct_checker (.*);
